/* rtl/psfp_pkg.sv */
// Package for the particle sensor frame parser: frame layout constants,
// header codes and the types shared by the parser and the top level.
// Depends on nothing.
`default_nettype none

package psfp_pkg;

    localparam int WORD_COUNT = 12;
    localparam int FRAME_LEN  = 2 * WORD_COUNT + 8;
    localparam int POS_W      = 6;
    localparam int STORE_AW   = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int INDEX_W    = 4;
    localparam int VALUE_W    = 16;
    localparam int TDATA_W    = 24;

    localparam logic [7:0] HDR_FIRST  = 8'h42;
    localparam logic [7:0] HDR_SECOND = 8'h4d;

    typedef logic [WORD_COUNT-1:0][VALUE_W-1:0] word_arr_t;

    typedef struct packed {
        logic done;
        logic ok;
    } frame_evt_t;

endpackage

`default_nettype wire

/* rtl/psfp_parser.sv */
// Byte-level frame parser: header hunt, running sum, data word capture and
// checksum compare. Depends on psfp_pkg.
`default_nettype none

module psfp_parser
    import psfp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             byte_valid,
    input  wire logic [7:0]       rx_byte,
    output logic                  at_final,
    output frame_evt_t            frame_evt,
    output word_arr_t             words
);

    localparam logic [POS_W-1:0] POS_HDR0   = '0;
    localparam logic [POS_W-1:0] POS_HDR1   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DATA   = POS_W'(4);
    localparam logic [POS_W-1:0] POS_CHK_HI = POS_W'(FRAME_LEN - 2);
    localparam logic [POS_W-1:0] POS_CHK_LO = POS_W'(FRAME_LEN - 1);

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [15:0]         sum_reg, sum_next;
    logic [7:0]          high_reg, high_next;
    logic [7:0]          check_hi_reg, check_hi_next;
    word_arr_t           store_reg;
    logic                store_we;
    logic [STORE_AW-1:0] store_addr;
    logic [POS_W-1:0]    rel;
    logic [15:0]         sum_add;

    assign rel     = pos_reg - POS_DATA;
    assign sum_add = sum_reg + {8'd0, rx_byte};

    always_comb
    begin
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        high_next     = high_reg;
        check_hi_next = check_hi_reg;
        store_we      = 1'b0;
        store_addr    = rel[STORE_AW:1];
        frame_evt     = '0;
        if (byte_valid)
        begin
            if (pos_reg == POS_HDR0)
            begin
                if (rx_byte == HDR_FIRST)
                begin
                    sum_next = {8'd0, rx_byte};
                    pos_next = POS_HDR1;
                end
            end
            else if (pos_reg == POS_HDR1)
            begin
                if (rx_byte == HDR_SECOND)
                begin
                    sum_next = sum_add;
                    pos_next = pos_reg + POS_W'(1);
                end
                else if (rx_byte == HDR_FIRST)
                begin
                    sum_next = {8'd0, rx_byte};
                    pos_next = POS_HDR1;
                end
                else
                begin
                    sum_next = '0;
                    pos_next = POS_HDR0;
                end
            end
            else if (pos_reg < POS_CHK_HI)
            begin
                sum_next = sum_add;
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg >= POS_DATA)
                begin
                    if (!rel[0])
                    begin
                        high_next = rx_byte;
                    end
                    else
                    begin
                        store_we = 1'b1;
                    end
                end
            end
            else if (pos_reg == POS_CHK_HI)
            begin
                check_hi_next = rx_byte;
                pos_next      = pos_reg + POS_W'(1);
            end
            else
            begin
                frame_evt.done = 1'b1;
                frame_evt.ok   = ({check_hi_reg, rx_byte} == sum_reg);
                sum_next       = '0;
                pos_next       = POS_HDR0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            sum_reg      <= '0;
            high_reg     <= '0;
            check_hi_reg <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            high_reg     <= high_next;
            check_hi_reg <= check_hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[store_addr] <= {high_reg, rx_byte};
        end
    end

    assign at_final = (pos_reg == POS_CHK_LO);
    assign words    = store_reg;

endmodule

`default_nettype wire

/* rtl/particle_sensor_frame_parser.sv */
// Top level of the particle sensor frame parser: input stream, parser,
// result drain buffer and output register. Depends on psfp_pkg, psfp_parser.
//
// Usage: received serial bytes enter on the s_axis channel, one request per
// byte. The parser hunts for the header 0x42 0x4d, sums the frame bytes and
// captures the twelve big-endian data words. On the final checksum byte the
// words are copied into a drain buffer, so the next frame's bytes keep being
// taken while results go out. Results leave on m_axis: twelve words with
// tuser high and tlast on the twelfth, or one failure request with tuser low,
// value 0 and tlast high. A header mismatch produces nothing.
// Throughput: one input byte per cycle while s_axis_tready is high. The
// final byte sets drain_busy_reg, then the first result enters the output
// register; results leave one per cycle while m_axis_tready is high, twelve
// for a good frame. s_axis_tready drops only while the parser awaits a final
// byte and the previous frame's results are still draining, and stays low
// until the drain buffer is empty. A stalled receiver holds the output
// register and drain buffer; reset returns to header hunt and empties both.
`default_nettype none

module particle_sensor_frame_parser
    import psfp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // [3:0] word_index, [19:4] word_value
    output logic                    m_axis_tuser,   // [0] frame_ok
    output logic                    m_axis_tlast
);

    localparam logic [STORE_AW-1:0] LAST_IDX = STORE_AW'(WORD_COUNT - 1);

    logic                at_final;
    logic                in_accept;
    frame_evt_t          frame_evt;
    word_arr_t           words;

    logic                drain_busy_reg;
    logic                drain_ok_reg;
    logic [STORE_AW-1:0] drain_idx_reg;
    word_arr_t           drain_buf_reg;
    logic                load;
    logic                load_last;

    logic                out_valid_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic                out_ok_reg;
    logic                out_last_reg;

    assign s_axis_tready = !(drain_busy_reg && at_final);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    psfp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_accept),
        .rx_byte    (s_axis_tdata),
        .at_final   (at_final),
        .frame_evt  (frame_evt),
        .words      (words)
    );

    assign load      = drain_busy_reg && (!out_valid_reg || m_axis_tready);
    assign load_last = !drain_ok_reg || (drain_idx_reg == LAST_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_busy_reg <= 1'b0;
            drain_ok_reg   <= 1'b0;
            drain_idx_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (frame_evt.done)
            begin
                drain_busy_reg <= 1'b1;
                drain_ok_reg   <= frame_evt.ok;
                drain_idx_reg  <= '0;
            end
            else if (load)
            begin
                drain_busy_reg <= !load_last;
                drain_idx_reg  <= drain_idx_reg + STORE_AW'(1);
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_evt.done)
        begin
            drain_buf_reg <= words;
        end
        if (load)
        begin
            out_index_reg <= drain_ok_reg ? INDEX_W'(drain_idx_reg) : '0;
            out_value_reg <= drain_ok_reg ? drain_buf_reg[drain_idx_reg] : '0;
            out_ok_reg    <= drain_ok_reg;
            out_last_reg  <= load_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W - INDEX_W - VALUE_W){1'b0}}, out_value_reg, out_index_reg};
    assign m_axis_tuser  = out_ok_reg;
    assign m_axis_tlast  = out_last_reg;

    a_stall_only_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> drain_busy_reg)
        else $error("input stalled with an empty drain buffer");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        frame_evt.done |-> !drain_busy_reg)
        else $error("frame completed while the drain buffer was busy");

    a_fail_result_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
            (m_axis_tlast && (m_axis_tdata[19:4] == 16'd0)))
        else $error("failure result not a single zero-valued last request");

    a_drain_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        drain_busy_reg |-> (drain_idx_reg <= LAST_IDX))
        else $error("drain index beyond the last data word");

endmodule

`default_nettype wire
